// ----- design/cbz_pkg.sv -----
// Shared types and constants of the cubic Bezier point generator.
`default_nettype none
package cbz_pkg;

  localparam int COORD_BITS = 16;
  localparam int SEG_BITS = 6;
  localparam logic [SEG_BITS-1:0] SEG_COUNT_RST = SEG_BITS'(10);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] p0_x;
    logic signed [COORD_BITS-1:0] p0_y;
    logic signed [COORD_BITS-1:0] p1_x;
    logic signed [COORD_BITS-1:0] p1_y;
    logic signed [COORD_BITS-1:0] p2_x;
    logic signed [COORD_BITS-1:0] p2_y;
    logic signed [COORD_BITS-1:0] p3_x;
    logic signed [COORD_BITS-1:0] p3_y;
  } cbz_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] curve_x;
    logic signed [COORD_BITS-1:0] curve_y;
    logic [SEG_BITS-1:0]          point_index;
    logic                         last_point;
  } cbz_out_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic issue;
  } cbz_cmd_t;

  typedef struct packed {
    logic div_done;
    logic issue_ready;
    logic last_issue;
  } cbz_sts_t;

endpackage
`default_nettype wire

// ----- design/cubic_bezier_point_generator.sv -----
// The first curve point is valid after the divide ends and the point has passed the three
// Horner lane stages and the output register; the divide begins when the item is accepted.
// A new item is accepted only after the last point of the previous one has been issued;
// points are issued one per cycle while the output is not stalled.
// Reset clears the controller, the pipeline valid bits and sets segment_count to 10.
`default_nettype none
module cubic_bezier_point_generator #(
  parameter int T_FRAC_BITS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [cbz_pkg::SEG_BITS-1:0]  cfg_wdata_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  cbz_pkg::cbz_in_t             in_item_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output cbz_pkg::cbz_out_t            out_item_o
);
  import cbz_pkg::*;

  logic [SEG_BITS-1:0] seg_count_q;
  cbz_cmd_t            cmd;
  cbz_sts_t            sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q <= SEG_COUNT_RST;
    end else if (cfg_we_i) begin
      seg_count_q <= cfg_wdata_i;
    end
  end

  cbz_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cbz_datapath #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_item_i),
    .seg_count_i (seg_count_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

// ----- design/cbz_horner_lane.sv -----
// Three-stage Horner evaluation of one coordinate polynomial, with rounding.
`default_nettype none
module cbz_horner_lane #(
  parameter int T_FRAC_BITS = 16
) (
  input  wire                                         clk_i,
  input  wire                                         en_i,
  input  wire [T_FRAC_BITS:0]                         t_i,
  input  wire signed [cbz_pkg::COORD_BITS+3:0]        a0_i,
  input  wire signed [cbz_pkg::COORD_BITS+3:0]        a1_i,
  input  wire signed [cbz_pkg::COORD_BITS+3:0]        a2_i,
  input  wire signed [cbz_pkg::COORD_BITS+3:0]        a3_i,
  output logic signed [cbz_pkg::COORD_BITS-1:0]       coord_o
);
  import cbz_pkg::*;

  localparam int CW = COORD_BITS + 4;
  localparam int TW = T_FRAC_BITS + 1;
  localparam int W1 = CW + T_FRAC_BITS + 2;
  localparam int W2 = W1 + T_FRAC_BITS + 2;
  localparam int W3 = W2 + T_FRAC_BITS + 2;
  localparam int SH = 3 * T_FRAC_BITS;

  logic signed [TW:0]    t0_sg, t1_sg, t2_sg;
  logic [TW-1:0]         t1_q, t2_q;
  logic signed [CW-1:0]  a1_q1, a0_q1, a0_q2;
  logic signed [W1-1:0]  m1, h1_d, h1_q;
  logic signed [W2-1:0]  m2, h2_d, h2_q;
  logic signed [W3-1:0]  m3, h3_d, h3_q;
  logic signed [W3-1:0]  rnd;

  assign t0_sg = $signed({1'b0, t_i});
  assign t1_sg = $signed({1'b0, t1_q});
  assign t2_sg = $signed({1'b0, t2_q});

  // The sum is the scaled curve value: ((a3*t + a2*S)*t + a1*S^2)*t + a0*S^3.
  assign m1   = a3_i * t0_sg;
  assign h1_d = m1 + (W1'(a2_i) <<< T_FRAC_BITS);
  assign m2   = h1_q * t1_sg;
  assign h2_d = m2 + (W2'(a1_q1) <<< (2 * T_FRAC_BITS));
  assign m3   = h2_q * t2_sg;
  assign h3_d = m3 + (W3'(a0_q2) <<< SH);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h1_q  <= h1_d;
      t1_q  <= t_i;
      a1_q1 <= a1_i;
      a0_q1 <= a0_i;
      h2_q  <= h2_d;
      t2_q  <= t1_q;
      a0_q2 <= a0_q1;
      h3_q  <= h3_d;
    end
  end

  // Round half up, then drop the fraction bits.
  assign rnd     = h3_q + (W3'(1) <<< (SH - 1));
  assign coord_o = rnd[SH +: COORD_BITS];

endmodule
`default_nettype wire

// ----- design/cbz_datapath.sv -----
// Datapath: coefficient setup, step divider, t generator and the output pipeline.
`default_nettype none
module cbz_datapath #(
  parameter int T_FRAC_BITS = 16
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  cbz_pkg::cbz_cmd_t              cmd_i,
  output cbz_pkg::cbz_sts_t              sts_o,
  input  cbz_pkg::cbz_in_t               in_item_i,
  input  wire [cbz_pkg::SEG_BITS-1:0]    seg_count_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output cbz_pkg::cbz_out_t              out_item_o
);
  import cbz_pkg::*;

  localparam int CW   = COORD_BITS + 4;
  localparam int TW   = T_FRAC_BITS + 1;
  localparam int CNTW = $clog2(T_FRAC_BITS + 2);

  function automatic logic signed [CW-1:0] mul3(input logic signed [CW-1:0] v);
    return (v <<< 1) + v;
  endfunction

  // Power-basis coefficients for x (index 0) and y (index 1).
  logic signed [CW-1:0] a0_q [2];
  logic signed [CW-1:0] a1_q [2];
  logic signed [CW-1:0] a2_q [2];
  logic signed [CW-1:0] a3_q [2];
  logic signed [CW-1:0] c0 [2];
  logic signed [CW-1:0] c1 [2];
  logic signed [CW-1:0] c2 [2];
  logic signed [CW-1:0] c3 [2];

  logic [SEG_BITS-1:0] n_q;
  logic [SEG_BITS-1:0] div_rem_q, div_rem_d;
  logic [TW-1:0]       div_quo_q;
  logic [CNTW-1:0]     div_cnt_q;
  logic [SEG_BITS:0]   div_r2;
  logic                div_ge;

  logic [TW-1:0]       t_q, t_d;
  logic [SEG_BITS-1:0] r_q, r_d;
  logic [SEG_BITS-1:0] k_q;
  logic [SEG_BITS:0]   r_sum;
  logic                r_wrap;

  logic                pipe_en;
  logic [2:0]          v_q;
  logic [SEG_BITS-1:0] idx_q [3];
  logic                last_q [3];
  logic                out_valid_q;
  cbz_out_t            out_item_q;
  logic signed [COORD_BITS-1:0] lane_coord [2];

  always_comb begin
    c0[0] = CW'(in_item_i.p0_x);
    c1[0] = CW'(in_item_i.p1_x);
    c2[0] = CW'(in_item_i.p2_x);
    c3[0] = CW'(in_item_i.p3_x);
    c0[1] = CW'(in_item_i.p0_y);
    c1[1] = CW'(in_item_i.p1_y);
    c2[1] = CW'(in_item_i.p2_y);
    c3[1] = CW'(in_item_i.p3_y);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 2; i++) begin
        a0_q[i] <= c0[i];
        a1_q[i] <= mul3(c1[i] - c0[i]);
        a2_q[i] <= mul3(c0[i] - (c1[i] <<< 1) + c2[i]);
        a3_q[i] <= c3[i] - c0[i] + mul3(c1[i] - c2[i]);
      end
    end
  end

  // Restoring division of 2^T_FRAC_BITS by the segment count, one bit a cycle.
  assign div_r2    = {div_rem_q, (div_cnt_q == '0)};
  assign div_ge    = div_r2 >= {1'b0, n_q};
  assign div_rem_d = div_ge ? SEG_BITS'(div_r2 - {1'b0, n_q}) : div_r2[SEG_BITS-1:0];

  // t steps by quotient, plus one whenever the remainder sum wraps.
  assign r_sum  = {1'b0, r_q} + {1'b0, div_rem_q};
  assign r_wrap = r_sum >= {1'b0, n_q};
  assign r_d    = r_wrap ? SEG_BITS'(r_sum - {1'b0, n_q}) : r_sum[SEG_BITS-1:0];
  assign t_d    = t_q + div_quo_q + TW'(r_wrap);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q       <= SEG_COUNT_RST;
      div_rem_q <= '0;
      div_quo_q <= '0;
      div_cnt_q <= '0;
      t_q       <= '0;
      r_q       <= '0;
      k_q       <= '0;
    end else if (cmd_i.load) begin
      n_q       <= (seg_count_i == '0) ? SEG_BITS'(1) : seg_count_i;
      div_rem_q <= '0;
      div_quo_q <= '0;
      div_cnt_q <= '0;
      t_q       <= '0;
      r_q       <= '0;
      k_q       <= '0;
    end else if (cmd_i.div_step) begin
      div_rem_q <= div_rem_d;
      div_quo_q <= {div_quo_q[TW-2:0], div_ge};
      div_cnt_q <= div_cnt_q + CNTW'(1);
    end else if (cmd_i.issue) begin
      t_q <= t_d;
      r_q <= r_d;
      k_q <= k_q + SEG_BITS'(1);
    end
  end

  // The whole pipeline holds while a finished item waits at the output.
  assign pipe_en = !out_valid_q || !out_stall_i;

  assign sts_o.div_done    = div_cnt_q == CNTW'(T_FRAC_BITS + 1);
  assign sts_o.issue_ready = pipe_en;
  assign sts_o.last_issue  = k_q == n_q;

  for (genvar g = 0; g < 2; g++) begin : g_lane
    cbz_horner_lane #(
      .T_FRAC_BITS(T_FRAC_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .en_i    (pipe_en),
      .t_i     (t_q),
      .a0_i    (a0_q[g]),
      .a1_i    (a1_q[g]),
      .a2_i    (a2_q[g]),
      .a3_i    (a3_q[g]),
      .coord_o (lane_coord[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      v_q         <= {v_q[1:0], cmd_i.issue};
      out_valid_q <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      idx_q[0]  <= k_q;
      last_q[0] <= k_q == n_q;
      idx_q[1]  <= idx_q[0];
      last_q[1] <= last_q[0];
      idx_q[2]  <= idx_q[1];
      last_q[2] <= last_q[1];
      out_item_q.curve_x     <= lane_coord[0];
      out_item_q.curve_y     <= lane_coord[1];
      out_item_q.point_index <= idx_q[2];
      out_item_q.last_point  <= last_q[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire

// ----- design/cbz_ctrl.sv -----
// Controller state machine: load, divide, then issue one curve point per cycle while the output is not stalled.
`default_nettype none
module cbz_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  cbz_pkg::cbz_sts_t  sts_i,
  output cbz_pkg::cbz_cmd_t  cmd_o
);
  import cbz_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_RUN  = 3'b100
  } cbz_state_e;

  cbz_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_RUN;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_RUN: begin
        cmd_o.issue = sts_i.issue_ready;
        if (sts_i.issue_ready && sts_i.last_issue) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != ST_IDLE;

endmodule
`default_nettype wire
